FILE: sv/srsd_pkg.sv
// Shared constants and types for the sound register sweep DMA block.
// No dependencies; used by sound_register_sweep_dma.
package srsd_pkg;

  localparam int RAM_DEPTH  = 16384;
  localparam int PORT_COUNT = 256;
  localparam int CHANNELS   = 4;
  localparam int RAM_AW     = $clog2(RAM_DEPTH);
  localparam int ADDR_EXT_W = 17;

  localparam logic [1:0] REQ_PORT = 2'd0;
  localparam logic [1:0] REQ_RAM  = 2'd1;
  localparam logic [1:0] REQ_TICK = 2'd2;

  localparam logic [1:0] VK_TONE  = 2'd0;
  localparam logic [1:0] VK_PCM   = 2'd1;
  localparam logic [1:0] VK_NOISE = 2'd2;

  localparam logic [1:0] CH_PCM   = 2'd1;
  localparam logic [1:0] CH_LAST  = 2'd3;

  // port numbers
  localparam logic [7:0] P_SRC0  = 8'h4A;
  localparam logic [7:0] P_SRC1  = 8'h4B;
  localparam logic [7:0] P_SRC2  = 8'h4C;
  localparam logic [7:0] P_LEN0  = 8'h4E;
  localparam logic [7:0] P_LEN1  = 8'h4F;
  localparam logic [7:0] P_DMACT = 8'h52;
  localparam logic [7:0] P_PER0  = 8'h80;
  localparam logic [7:0] P_PER2L = 8'h84;
  localparam logic [7:0] P_PER2H = 8'h85;
  localparam logic [7:0] P_PER7  = 8'h87;
  localparam logic [7:0] P_VOL0  = 8'h88;
  localparam logic [7:0] P_VOL1  = 8'h89;
  localparam logic [7:0] P_VOL3  = 8'h8B;
  localparam logic [7:0] P_SWSTP = 8'h8C;
  localparam logic [7:0] P_SWINT = 8'h8D;
  localparam logic [7:0] P_NOISE = 8'h8E;
  localparam logic [7:0] P_CTRL  = 8'h90;
  localparam logic [7:0] P_OUTCT = 8'h91;
  localparam logic [7:0] P_PCMV  = 8'h94;

  localparam logic [10:0] PERIOD_SILENT_RAW = 11'h7FF;
  localparam logic [11:0] PERIOD_SILENT     = 12'd2048;

  typedef enum logic [6:0] {
    ST_CLEAR     = 7'b0000001,
    ST_IDLE      = 7'b0000010,
    ST_DMA_START = 7'b0000100,
    ST_DMA_CHK   = 7'b0001000,
    ST_DMA_DATA  = 7'b0010000,
    ST_SWEEP     = 7'b0100000,
    ST_EMIT      = 7'b1000000
  } state_t;

  // DMA period in samples, selected by rate bits 1..0
  function automatic logic [1:0] dma_period(input logic [1:0] sel);
    logic [1:0] r;
    case (sel)
      2'd0:    r = 2'd3;
      2'd1:    r = 2'd2;
      2'd2:    r = 2'd2;
      default: r = 2'd1;
    endcase
    return r;
  endfunction

  // floor(117.6 * (v + 1)) = 117*(v+1) + floor(3*(v+1)/5); 3/5 as 615/1024
  function automatic logic [15:0] sweep_len(input logic [7:0] v);
    logic [8:0]  m;
    logic [18:0] frac;
    logic [15:0] base;
    m    = {1'b0, v} + 9'd1;
    frac = 19'(m) * 19'd615;
    base = 16'(m) * 16'd117;
    return base + 16'(frac[18:10]);
  endfunction

endpackage

FILE: sv/sound_register_sweep_dma.sv
// Top level of the sound register sweep DMA block: port decode, sample RAM,
// sound DMA and channel-2 sweep sequencer. Depends on srsd_pkg.
// Register model of a four-channel sound unit. Each input transaction is a
// port write (tuser 0), a sample RAM write (tuser 1) or a time tick of
// "samples" samples (tuser 2); every transaction, tuser 3 included, yields
// four result transactions, channels 0..3, the last with tlast, showing the
// state after it. After reset the sample RAM is cleared one byte a cycle,
// all RAM_DEPTH (16384) bytes, while in_tready stays low. Port and RAM
// writes go straight to result output. A tick additionally passes through
// the DMA start state, then a check and a data state per DMA byte moved
// (registered RAM read) plus a closing check unless the byte count runs
// out, and the sweep state, visited once more per sweep step plus a closing
// check when the sweep is active, so its length follows the sample count and
// the DMA and sweep rates. The next transaction is taken while the last
// result still waits in the output register.
module sound_register_sweep_dma (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,  // address[13:0], value[21:14], samples[37:22], zero[39:38]
  input  logic [1:0]  in_tuser,  // req_type[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata, // period[11:0], vol_left[15:12], vol_right[19:16],
                                 // enabled[20], voice_kind[22:21], pcm_left[26:23],
                                 // pcm_right[30:27], noise_mode[33:31],
                                 // noise_reset_seen[34], dma_busy[35], zero[39:36]
  output logic [1:0]  out_tuser, // channel[1:0]
  output logic        out_tlast  // last
);

  localparam int AW = srsd_pkg::RAM_AW;
  localparam int XW = srsd_pkg::ADDR_EXT_W;

  srsd_pkg::state_t state_r, state_nxt;

  // sample RAM, one write and one read port, registered read
  logic [7:0]    ram_mem [srsd_pkg::RAM_DEPTH];
  logic [AW-1:0] clr_idx_r;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic [7:0]    ram_q_r;
  logic          rd_ok_r;

  // channel and port state
  logic [11:0] period_r [srsd_pkg::CHANNELS];
  logic [7:0]  per_lo_r [srsd_pkg::CHANNELS];
  logic [2:0]  per_hi_r [srsd_pkg::CHANNELS];
  logic [3:0]  vl_r     [srsd_pkg::CHANNELS];
  logic [3:0]  vr_r     [srsd_pkg::CHANNELS];
  logic [7:0]  ctrl_r;
  logic [7:0]  sw_delta_r;
  logic [15:0] sw_int_r;
  logic signed [17:0] sw_cd_r;
  logic [2:0]  noise_sel_r;
  logic        noise_flag_r;
  logic [3:0]  pcm_l_r, pcm_r_r;
  logic [7:0]  src_b0_r, src_b1_r, src_b2_r, len_b0_r, len_b1_r;
  logic [23:0] dma_src_r;
  logic [15:0] dma_rem_r;
  logic [1:0]  dma_rate_r;
  logic signed [17:0] dma_cd_r;
  logic [15:0] nsamp_r;
  logic [1:0]  ch_r;
  // the sweep countdown is taken down on the first sweep visit of a tick
  logic        sw_first_r;

  logic        out_tvalid_r;
  logic [39:0] out_tdata_r;
  logic [1:0]  out_tuser_r;
  logic        out_tlast_r;

  // input fields
  logic [1:0]  req;
  logic [13:0] addr;
  logic [7:0]  val;
  logic [15:0] nsamp;
  logic [7:0]  port;
  logic [XW-1:0] addr_x, src_x;
  logic        in_acc;
  logic        emit_load;

  assign req    = in_tuser;
  assign addr   = in_tdata[13:0];
  assign val    = in_tdata[21:14];
  assign nsamp  = in_tdata[37:22];
  assign port   = addr[7:0];
  assign addr_x = XW'(addr);
  assign src_x  = XW'(dma_src_r[13:0]);

  assign in_tready = (state_r == srsd_pkg::ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign emit_load = (state_r == srsd_pkg::ST_EMIT) && (!out_tvalid_r || out_tready);

  // period from the byte pair, with the new byte merged in
  logic [1:0]  pch;
  logic [10:0] praw;
  assign pch  = port[2:1];
  assign praw = port[0] ? {val[2:0], per_lo_r[pch]} : {per_hi_r[pch], val};

  // sweep step
  logic [11:0] sw_sum;
  logic [10:0] sw_p;
  assign sw_sum = period_r[2] + {{4{sw_delta_r[7]}}, sw_delta_r};
  assign sw_p   = sw_sum[10:0];

  logic dma_busy;
  assign dma_busy = (dma_rate_r != 2'd0) && (dma_rem_r != 16'd0);

  // RAM write port: clearing pass or RAM write transaction
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_idx_r;
    ram_wdata = 8'd0;
    if (state_r == srsd_pkg::ST_CLEAR) begin
      ram_we = 1'b1;
    end else if (in_acc && req == srsd_pkg::REQ_RAM &&
                 addr_x < XW'(srsd_pkg::RAM_DEPTH)) begin
      ram_we    = 1'b1;
      ram_waddr = addr_x[AW-1:0];
      ram_wdata = val;
    end
  end

  always_ff @(posedge clk) begin
    if (ram_we) begin
      ram_mem[ram_waddr] <= ram_wdata;
    end
    ram_q_r <= ram_mem[src_x[AW-1:0]];
    rd_ok_r <= src_x < XW'(srsd_pkg::RAM_DEPTH);
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      srsd_pkg::ST_CLEAR: begin
        if (clr_idx_r == AW'(srsd_pkg::RAM_DEPTH - 1)) state_nxt = srsd_pkg::ST_IDLE;
      end
      srsd_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_nxt = (req == srsd_pkg::REQ_TICK) ? srsd_pkg::ST_DMA_START
                                                  : srsd_pkg::ST_EMIT;
        end
      end
      srsd_pkg::ST_DMA_START: begin
        state_nxt = dma_busy ? srsd_pkg::ST_DMA_CHK : srsd_pkg::ST_SWEEP;
      end
      srsd_pkg::ST_DMA_CHK: begin
        state_nxt = (dma_cd_r <= 18'sd0) ? srsd_pkg::ST_DMA_DATA : srsd_pkg::ST_SWEEP;
      end
      srsd_pkg::ST_DMA_DATA: begin
        state_nxt = (dma_rem_r == 16'd1) ? srsd_pkg::ST_SWEEP : srsd_pkg::ST_DMA_CHK;
      end
      srsd_pkg::ST_SWEEP: begin
        // first visit takes the countdown down; later visits step while it is <= 0
        if (sw_delta_r == 8'd0 || !ctrl_r[6] || sw_int_r == 16'd0 ||
            (!sw_first_r && sw_cd_r > 18'sd0)) begin
          state_nxt = srsd_pkg::ST_EMIT;
        end
      end
      srsd_pkg::ST_EMIT: begin
        if (emit_load && ch_r == srsd_pkg::CH_LAST) state_nxt = srsd_pkg::ST_IDLE;
      end
      default: state_nxt = srsd_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= srsd_pkg::ST_CLEAR;
      clr_idx_r    <= '0;
      ctrl_r       <= '0;
      sw_delta_r   <= '0;
      sw_int_r     <= '0;
      sw_cd_r      <= '0;
      noise_sel_r  <= '0;
      noise_flag_r <= 1'b0;
      pcm_l_r      <= '0;
      pcm_r_r      <= '0;
      src_b0_r     <= '0;
      src_b1_r     <= '0;
      src_b2_r     <= '0;
      len_b0_r     <= '0;
      len_b1_r     <= '0;
      dma_src_r    <= '0;
      dma_rem_r    <= '0;
      dma_rate_r   <= '0;
      dma_cd_r     <= '0;
      nsamp_r      <= '0;
      ch_r         <= '0;
      sw_first_r   <= 1'b0;
      out_tvalid_r <= 1'b0;
      for (int i = 0; i < srsd_pkg::CHANNELS; i++) begin
        period_r[i] <= '0;
        per_lo_r[i] <= '0;
        per_hi_r[i] <= '0;
        vl_r[i]     <= '0;
        vr_r[i]     <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (state_r == srsd_pkg::ST_CLEAR) clr_idx_r <= clr_idx_r + AW'(1);

      if (in_acc) begin
        nsamp_r    <= nsamp;
        ch_r       <= '0;
        sw_first_r <= 1'b1;
        if (req == srsd_pkg::REQ_PORT) begin
          if (port >= srsd_pkg::P_PER0 && port <= srsd_pkg::P_PER7) begin
            if (port[0]) per_hi_r[pch] <= val[2:0];
            else         per_lo_r[pch] <= val;
            period_r[pch] <= (praw == srsd_pkg::PERIOD_SILENT_RAW) ?
                             srsd_pkg::PERIOD_SILENT : {1'b0, praw};
          end
          if (port >= srsd_pkg::P_VOL0 && port <= srsd_pkg::P_VOL3) begin
            vl_r[port[1:0]] <= val[7:4];
            vr_r[port[1:0]] <= val[3:0];
          end
          case (port)
            srsd_pkg::P_SWSTP: sw_delta_r <= val;
            srsd_pkg::P_SWINT: begin
              sw_int_r <= srsd_pkg::sweep_len(val);
              sw_cd_r  <= $signed({2'b00, srsd_pkg::sweep_len(val)});
            end
            srsd_pkg::P_NOISE: begin
              noise_sel_r <= val[2:0];
              if (val[3]) noise_flag_r <= 1'b1;
            end
            srsd_pkg::P_CTRL: ctrl_r <= val;
            srsd_pkg::P_PCMV: begin
              pcm_l_r <= 4'({2'b00, val[3:2]} * 4'd5);
              pcm_r_r <= 4'({2'b00, val[1:0]} * 4'd5);
            end
            srsd_pkg::P_SRC0: begin
              src_b0_r  <= val;
              dma_src_r <= {src_b2_r, src_b1_r, val};
            end
            srsd_pkg::P_SRC1: begin
              src_b1_r  <= val;
              dma_src_r <= {src_b2_r, val, src_b0_r};
            end
            srsd_pkg::P_SRC2: begin
              src_b2_r  <= val;
              dma_src_r <= {val, src_b1_r, src_b0_r};
            end
            srsd_pkg::P_LEN0: begin
              len_b0_r  <= val;
              dma_rem_r <= {len_b1_r, val};
            end
            srsd_pkg::P_LEN1: begin
              len_b1_r  <= val;
              dma_rem_r <= {val, len_b0_r};
            end
            srsd_pkg::P_DMACT: begin
              if (val[7]) begin
                dma_rate_r <= srsd_pkg::dma_period(val[1:0]);
                dma_cd_r   <= $signed({16'd0, srsd_pkg::dma_period(val[1:0])});
              end
            end
            default: ;
          endcase
        end
      end

      if (state_r == srsd_pkg::ST_DMA_START && dma_busy) begin
        dma_cd_r <= dma_cd_r - $signed({2'b00, nsamp_r});
      end

      // byte read issued in DMA_CHK lands here
      if (state_r == srsd_pkg::ST_DMA_DATA) begin
        vl_r[srsd_pkg::CH_PCM] <= rd_ok_r ? ram_q_r[7:4] : 4'd0;
        vr_r[srsd_pkg::CH_PCM] <= rd_ok_r ? ram_q_r[3:0] : 4'd0;
        dma_src_r <= dma_src_r + 24'd1;
        dma_rem_r <= dma_rem_r - 16'd1;
        if (dma_rem_r == 16'd1) dma_rate_r <= '0;
        else dma_cd_r <= dma_cd_r + $signed({16'd0, dma_rate_r});
      end

      if (state_r == srsd_pkg::ST_SWEEP) begin
        sw_first_r <= 1'b0;
        if (sw_delta_r != 8'd0 && ctrl_r[6]) begin
          if (sw_int_r == 16'd0) begin
            sw_cd_r <= '0;
          end else if (sw_first_r) begin
            sw_cd_r <= sw_cd_r - $signed({2'b00, nsamp_r});
          end else if (sw_cd_r <= 18'sd0) begin
            sw_cd_r     <= sw_cd_r + $signed({2'b00, sw_int_r});
            per_lo_r[2] <= sw_p[7:0];
            per_hi_r[2] <= sw_p[10:8];
            period_r[2] <= {1'b0, sw_p};
          end
        end
      end

      if (emit_load) begin
        out_tvalid_r <= 1'b1;
        ch_r         <= ch_r + 2'd1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // result fields for the channel being sent
  logic [1:0] kind;
  always_comb begin
    kind = srsd_pkg::VK_TONE;
    if (ch_r == srsd_pkg::CH_PCM && ctrl_r[5]) kind = srsd_pkg::VK_PCM;
    else if (ch_r == srsd_pkg::CH_LAST && ctrl_r[7]) kind = srsd_pkg::VK_NOISE;
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      out_tdata_r <= {4'd0, dma_busy, noise_flag_r, noise_sel_r, pcm_r_r, pcm_l_r,
                      kind, ctrl_r[ch_r], vr_r[ch_r], vl_r[ch_r], period_r[ch_r]};
      out_tuser_r <= ch_r;
      out_tlast_r <= (ch_r == srsd_pkg::CH_LAST);
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;
  assign out_tlast  = out_tlast_r;

  // checks
  a_last_ch: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser == srsd_pkg::CH_LAST)
    else $error("tlast on a channel other than the last");

  a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == srsd_pkg::ST_CLEAR |-> !in_tready)
    else $error("input taken during RAM clearing");

  a_dma_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == srsd_pkg::ST_DMA_DATA |=> dma_rem_r == $past(dma_rem_r) - 16'd1)
    else $error("DMA count not decremented per byte");

  a_dma_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == srsd_pkg::ST_DMA_DATA |-> dma_busy)
    else $error("DMA byte moved while idle");

endmodule

FILE: bench/sound_register_sweep_dma_test.sv
// Testbench for sound_register_sweep_dma: directed and random port, RAM and
// tick transactions, checked against a behavioral status predictor.
// Depends on srsd_pkg and sound_register_sweep_dma.
`timescale 1ns / 1ps

module sound_register_sweep_dma_test;

  // one status result as the block reports it
  typedef struct packed {
    logic [1:0]  channel;
    logic [11:0] period;
    logic [3:0]  vol_left;
    logic [3:0]  vol_right;
    logic        enabled;
    logic [1:0]  voice_kind;
    logic [3:0]  pcm_left;
    logic [3:0]  pcm_right;
    logic [2:0]  noise_mode;
    logic        noise_reset_seen;
    logic        dma_busy;
    logic        last;
  } chan_status_t;

  // Behavioral copy of the register file; notes each accepted request,
  // queues the four channel reports it causes and checks reports in order.
  class sound_status_board;
    logic [7:0]  port_b [srsd_pkg::PORT_COUNT];
    logic [7:0]  ram [srsd_pkg::RAM_DEPTH];
    logic [11:0] per [srsd_pkg::CHANNELS];
    logic [3:0]  vl [srsd_pkg::CHANNELS];
    logic [3:0]  vr [srsd_pkg::CHANNELS];
    logic        en [srsd_pkg::CHANNELS];
    logic [7:0]  sw_step;
    logic [15:0] sw_len;
    int          sw_cnt;
    logic [2:0]  nsel;
    logic        nreset;
    logic [3:0]  pcm_l, pcm_r;
    logic [23:0] dma_src;
    logic [15:0] dma_left;
    logic [1:0]  dma_per;
    int          dma_cnt;
    chan_status_t pending [$];
    int          errors;

    function new();
      foreach (port_b[i]) port_b[i] = '0;
      foreach (ram[i]) ram[i] = '0;
      for (int c = 0; c < srsd_pkg::CHANNELS; c++) begin
        per[c] = '0; vl[c] = '0; vr[c] = '0; en[c] = 1'b0;
      end
      sw_step = '0; sw_len = '0; sw_cnt = 0;
      nsel = '0; nreset = 1'b0; pcm_l = '0; pcm_r = '0;
      dma_src = '0; dma_left = '0; dma_per = '0; dma_cnt = 0;
      errors = 0;
    endfunction

    function void load_period(int ch);
      logic [10:0] p;
      p = {port_b[srsd_pkg::P_PER0 + 2*ch + 1][2:0], port_b[srsd_pkg::P_PER0 + 2*ch]};
      per[ch] = (p == srsd_pkg::PERIOD_SILENT_RAW) ? srsd_pkg::PERIOD_SILENT : {1'b0, p};
    endfunction

    function void apply_port(logic [7:0] p, logic [7:0] v);
      logic [1:0] tab [4];
      tab = '{2'd3, 2'd2, 2'd2, 2'd1};
      port_b[p] = v;
      if (p >= srsd_pkg::P_PER0 && p <= srsd_pkg::P_PER7)
        load_period((p - srsd_pkg::P_PER0) / 2);
      else if (p >= srsd_pkg::P_VOL0 && p <= srsd_pkg::P_VOL3) begin
        vl[p - srsd_pkg::P_VOL0] = v[7:4];
        vr[p - srsd_pkg::P_VOL0] = v[3:0];
      end else begin
        case (p)
          srsd_pkg::P_SWSTP: sw_step = v;
          srsd_pkg::P_SWINT: begin
            sw_len = 16'((1176 * (int'(v) + 1)) / 10);
            sw_cnt = sw_len;
          end
          srsd_pkg::P_NOISE: begin
            nsel = v[2:0];
            if (v[3]) nreset = 1'b1;
          end
          srsd_pkg::P_CTRL: for (int c = 0; c < srsd_pkg::CHANNELS; c++) en[c] = v[c];
          srsd_pkg::P_OUTCT: port_b[srsd_pkg::P_OUTCT] = v | 8'h80;
          srsd_pkg::P_PCMV: begin
            pcm_l = 4'(v[3:2] * 5);
            pcm_r = 4'(v[1:0] * 5);
          end
          srsd_pkg::P_SRC0, srsd_pkg::P_SRC1, srsd_pkg::P_SRC2:
            dma_src = {port_b[srsd_pkg::P_SRC2], port_b[srsd_pkg::P_SRC1],
                       port_b[srsd_pkg::P_SRC0]};
          srsd_pkg::P_LEN0, srsd_pkg::P_LEN1:
            dma_left = {port_b[srsd_pkg::P_LEN1], port_b[srsd_pkg::P_LEN0]};
          srsd_pkg::P_DMACT: if (v[7]) begin
            dma_per = tab[v[1:0]];
            dma_cnt = dma_per;
          end
          default: ;
        endcase
      end
    endfunction

    function void advance(int n);
      logic [15:0] d;
      logic [10:0] p;
      // DMA runs first, feeding channel-1 volume
      if (dma_per != 0 && dma_left != 0) begin
        dma_cnt -= n;
        while (dma_cnt <= 0) begin
          apply_port(srsd_pkg::P_VOL1, ram[dma_src[13:0]]);
          dma_src = dma_src + 24'd1;
          dma_left = dma_left - 16'd1;
          if (dma_left == 0) begin
            dma_per = '0;
            port_b[srsd_pkg::P_DMACT][7] = 1'b0;
            break;
          end
          dma_cnt += dma_per;
        end
      end
      // channel-2 sweep; raw 11-bit result, no silent conversion
      if (sw_step != 0 && port_b[srsd_pkg::P_CTRL][6]) begin
        if (sw_len == 0) sw_cnt = 0;
        else begin
          sw_cnt -= n;
          while (sw_cnt <= 0) begin
            d = sw_step[7] ? {8'hFF, sw_step} : {8'h00, sw_step};
            p = 11'(per[2] + d);
            sw_cnt += sw_len;
            port_b[srsd_pkg::P_PER2L] = p[7:0];
            port_b[srsd_pkg::P_PER2H][2:0] = p[10:8];
            per[2] = {1'b0, p};
          end
        end
      end
    endfunction

    function void note_request(logic [1:0] kind, logic [13:0] addr, logic [7:0] val,
                               logic [15:0] n);
      chan_status_t s;
      case (kind)
        srsd_pkg::REQ_PORT: apply_port(addr[7:0], val);
        srsd_pkg::REQ_RAM:  ram[addr] = val;
        srsd_pkg::REQ_TICK: advance(n);
        default: ;
      endcase
      for (int c = 0; c < srsd_pkg::CHANNELS; c++) begin
        s.channel = 2'(c);
        s.period = per[c];
        s.vol_left = vl[c];
        s.vol_right = vr[c];
        s.enabled = en[c];
        s.voice_kind = srsd_pkg::VK_TONE;
        if (c == srsd_pkg::CH_PCM && port_b[srsd_pkg::P_CTRL][5])
          s.voice_kind = srsd_pkg::VK_PCM;
        else if (c == srsd_pkg::CH_LAST && port_b[srsd_pkg::P_CTRL][7])
          s.voice_kind = srsd_pkg::VK_NOISE;
        s.pcm_left = pcm_l;
        s.pcm_right = pcm_r;
        s.noise_mode = nsel;
        s.noise_reset_seen = nreset;
        s.dma_busy = (dma_per != 0 && dma_left != 0);
        s.last = (c == srsd_pkg::CH_LAST);
        pending.push_back(s);
      end
    endfunction

    function void flag(string what, int e, int a);
      errors++;
      if (errors <= 10)
        $display("MISMATCH %s: expected %0h, got %0h", what, e, a);
    endfunction

    function void check_status(chan_status_t a);
      chan_status_t e;
      if (pending.size() == 0) begin
        flag("unexpected status transaction, channel", 0, a.channel);
        return;
      end
      e = pending.pop_front();
      if (e.channel != a.channel) flag("channel", e.channel, a.channel);
      if (e.period != a.period) flag("period", e.period, a.period);
      if (e.vol_left != a.vol_left) flag("vol_left", e.vol_left, a.vol_left);
      if (e.vol_right != a.vol_right) flag("vol_right", e.vol_right, a.vol_right);
      if (e.enabled != a.enabled) flag("enabled", e.enabled, a.enabled);
      if (e.voice_kind != a.voice_kind) flag("voice_kind", e.voice_kind, a.voice_kind);
      if (e.pcm_left != a.pcm_left) flag("pcm_left", e.pcm_left, a.pcm_left);
      if (e.pcm_right != a.pcm_right) flag("pcm_right", e.pcm_right, a.pcm_right);
      if (e.noise_mode != a.noise_mode) flag("noise_mode", e.noise_mode, a.noise_mode);
      if (e.noise_reset_seen != a.noise_reset_seen)
        flag("noise_reset_seen", e.noise_reset_seen, a.noise_reset_seen);
      if (e.dma_busy != a.dma_busy) flag("dma_busy", e.dma_busy, a.dma_busy);
      if (e.last != a.last) flag("last", e.last, a.last);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;

  sound_status_board board = new();
  int  sent = 0;
  int  reports = 0;
  int  idle_cycles = 0;
  bit  held_off = 1'b0;

  sound_register_sweep_dma uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // offer one request transaction and hold it until the block takes it
  task automatic send(logic [1:0] kind, logic [13:0] addr, logic [7:0] val,
                      logic [15:0] n);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= kind;
    in_tdata <= {2'b00, n, val, addr};
    do @(posedge clk); while (!in_tready);
    board.note_request(kind, addr, val, n);
    sent++;
  endtask

  task automatic port_wr(logic [7:0] p, logic [7:0] v);
    send(srsd_pkg::REQ_PORT, {6'd0, p}, v, 16'($urandom));
  endtask

  task automatic tick(logic [15:0] n);
    send(srsd_pkg::REQ_TICK, 14'($urandom), 8'($urandom), n);
  endtask

  // short tick counts keep DMA and sweep loops cheap; rarely a long one
  function automatic logic [15:0] pick_samples();
    if ($urandom_range(0, 49) == 0) return 16'($urandom);
    return 16'($urandom_range(0, 64));
  endfunction

  // full DMA setup followed by ticks that drain some or all of it
  task automatic dma_run();
    port_wr(srsd_pkg::P_SRC0, 8'($urandom));
    port_wr(srsd_pkg::P_SRC1, 8'($urandom));
    port_wr(srsd_pkg::P_SRC2, 8'($urandom));
    port_wr(srsd_pkg::P_LEN0, 8'($urandom_range(1, 40)));
    port_wr(srsd_pkg::P_LEN1,
            ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 3)) : 8'h00);
    port_wr(srsd_pkg::P_DMACT, {1'b1, 5'($urandom), 2'($urandom)});
    repeat ($urandom_range(1, 4)) tick(16'($urandom_range(0, 24)));
  endtask

  // sweep setup with the sweep enable bit (bit 6) set in the control register
  task automatic sweep_run();
    port_wr(srsd_pkg::P_SWSTP, 8'($urandom));
    port_wr(srsd_pkg::P_SWINT,
            ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 2)));
    port_wr(srsd_pkg::P_CTRL, 8'($urandom) | 8'h40);
    repeat ($urandom_range(1, 3)) tick(16'($urandom_range(0, 400)));
  endtask

  task automatic random_item();
    int r;
    logic [7:0] ports [16];
    ports = '{srsd_pkg::P_SRC0, srsd_pkg::P_SRC1, srsd_pkg::P_SRC2, srsd_pkg::P_LEN0,
              srsd_pkg::P_LEN1, srsd_pkg::P_DMACT, srsd_pkg::P_PER0, 8'h81,
              srsd_pkg::P_PER2L, srsd_pkg::P_PER7, srsd_pkg::P_VOL0, srsd_pkg::P_VOL1,
              srsd_pkg::P_SWSTP, srsd_pkg::P_NOISE, srsd_pkg::P_CTRL, srsd_pkg::P_PCMV};
    r = $urandom_range(0, 99);
    if (r < 35) begin
      if (ports[r % 16] == srsd_pkg::P_LEN1 && $urandom_range(0, 9) != 0)
        port_wr(srsd_pkg::P_LEN1, 8'h00);
      else port_wr(ports[r % 16], 8'($urandom));
    end else if (r < 45)
      send(srsd_pkg::REQ_PORT, 14'($urandom), 8'($urandom), 16'($urandom));
    else if (r < 65) send(srsd_pkg::REQ_RAM, 14'($urandom), 8'($urandom), 16'($urandom));
    else if (r < 95) tick(pick_samples());
    else send(2'd3, 14'($urandom), 8'($urandom), 16'($urandom));
  endtask

  // result side: random stalls plus one long hold-off that fills the block
  always @(posedge clk) begin
    if (!held_off && reports >= 200) begin
      held_off <= 1'b1;
      out_tready <= 1'b0;
      repeat (600) @(posedge clk);
      out_tready <= 1'b1;
    end else begin
      out_tready <= (pick_gap() == 0) || ($urandom_range(0, 1) == 1);
    end
  end

  // result transactions go straight to the checker
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      board.check_status({out_tuser, out_tdata[11:0], out_tdata[15:12], out_tdata[19:16],
                          out_tdata[20], out_tdata[22:21], out_tdata[26:23],
                          out_tdata[30:27], out_tdata[33:31], out_tdata[34],
                          out_tdata[35], out_tlast});
      reports++;
    end
  end

  // watchdog on cycles with no transaction on either side; covers the RAM
  // clear after reset and the longest legal DMA tick
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 400000) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset state, aliasing, odd kinds, edges of every field
    send(2'd3, 14'h3FFF, 8'hFF, 16'hFFFF);
    send(srsd_pkg::REQ_PORT, 14'h3F88, 8'hA5, 16'h0000);    // port number above 255
    send(srsd_pkg::REQ_RAM, 14'h0000, 8'hFF, 16'h0000);
    send(srsd_pkg::REQ_RAM, 14'h3FFF, 8'h5A, 16'h0000);
    port_wr(srsd_pkg::P_PER0, 8'hFF);
    port_wr(8'h81, 8'h07);                                   // silent period
    port_wr(srsd_pkg::P_PER2L, 8'hFE);
    port_wr(srsd_pkg::P_PER2H, 8'hFF);
    port_wr(srsd_pkg::P_NOISE, 8'h0F);                       // noise reset flag
    port_wr(srsd_pkg::P_OUTCT, 8'h00);
    port_wr(srsd_pkg::P_PCMV, 8'h0F);
    port_wr(srsd_pkg::P_CTRL, 8'hFF);
    port_wr(srsd_pkg::P_SWSTP, 8'h05);
    port_wr(srsd_pkg::P_SWINT, 8'h00);
    tick(16'd300);                                           // sweep wraps past 2047
    port_wr(srsd_pkg::P_SWSTP, 8'h80);
    port_wr(srsd_pkg::P_SWINT, 8'hFF);
    tick(16'hFFFF);
    // DMA with source wrapping at 24 bits, then stalled by a zero count
    port_wr(srsd_pkg::P_SRC0, 8'hFF);
    port_wr(srsd_pkg::P_SRC1, 8'hFF);
    port_wr(srsd_pkg::P_SRC2, 8'hFF);
    port_wr(srsd_pkg::P_LEN0, 8'h06);
    port_wr(srsd_pkg::P_DMACT, 8'h83);
    tick(16'd3);
    port_wr(srsd_pkg::P_LEN0, 8'h00);
    tick(16'd5);

    while (sent < 360) begin
      if (sent > 180 && sent < 190) begin
        // quiet the sender until every report has come back
        in_tvalid <= 1'b0;
        while (board.pending.size() != 0) @(posedge clk);
      end
      case ($urandom_range(0, 9))
        0, 1:    dma_run();
        2:       sweep_run();
        default: random_item();
      endcase
    end
    in_tvalid <= 1'b0;

    while (board.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (board.errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
